@@ rtl/core/multi_frame_association_confirm_core_defines.svh @@
// Assertion helpers shared by the core.
`ifndef MULTI_FRAME_ASSOCIATION_CONFIRM_CORE_DEFINES_SVH
`define MULTI_FRAME_ASSOCIATION_CONFIRM_CORE_DEFINES_SVH

// same-cycle implication
`define MFAC_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication
`define MFAC_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error(msg);

`endif

@@ rtl/core/mfac_pkg.sv @@
`timescale 1ns / 1ps
package mfac_pkg;

    typedef struct packed {
        logic [31:0] candidate_key;
        logic [31:0] frame_number;
        logic [16:0] top_score;
        logic [16:0] next_score;
        logic        gate_ok;
        logic        target_present;
        logic [31:0] target_epoch;
        logic signed [31:0] target_tracklet;
        logic        split_merge_flag;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  decision;
        logic        attached_valid;
        logic [31:0] attached_epoch;
        logic [30:0] attached_tracklet;
        logic [7:0]  hit_count;
    } out_item_t;

    localparam logic [2:0] DEC_MATCHED   = 3'd0;
    localparam logic [2:0] DEC_UNMATCHED = 3'd1;
    localparam logic [2:0] DEC_AMBIGUOUS = 3'd2;
    localparam logic [2:0] DEC_TENTATIVE = 3'd3;
    localparam logic [2:0] DEC_COOLDOWN  = 3'd4;
    localparam logic [2:0] DEC_REJECTED  = 3'd5;

    localparam logic [2:0] CFG_CONFIRM_FRAMES   = 3'd0;
    localparam logic [2:0] CFG_MISS_LIMIT       = 3'd1;
    localparam logic [2:0] CFG_COOLDOWN_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_MARGIN_THRESHOLD = 3'd3;
    localparam logic [2:0] CFG_HYSTERESIS_BONUS = 3'd4;
    localparam logic [2:0] CFG_ENTRY_LIMIT      = 3'd5;

    localparam logic [7:0]  RST_CONFIRM_FRAMES   = 8'd3;
    localparam logic [7:0]  RST_MISS_LIMIT       = 8'd3;
    localparam logic [31:0] RST_COOLDOWN_LENGTH  = 32'd10;
    localparam logic [17:0] RST_MARGIN_THRESHOLD = 18'd6554;
    localparam logic [17:0] RST_HYSTERESIS_BONUS = 18'd3277;
    localparam logic [6:0]  RST_ENTRY_LIMIT      = 7'd64;

    localparam logic [16:0] SCORE_ONE = 17'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_RESOLVE,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan_rd;
        logic resolve;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_invalid;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/mfac_ram.sv @@
`timescale 1ns / 1ps
module mfac_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/mfac_ctrl.sv @@
`timescale 1ns / 1ps
module mfac_ctrl import mfac_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_CHECK;
            ST_CHECK:   state_next = sts.in_invalid ? ST_RESOLVE : ST_SCAN;
            ST_SCAN:    if (sts.scan_done) state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_OUT;
            ST_OUT:     if (sts.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_SCAN:    cmd.scan_rd  = 1'b1;
            ST_RESOLVE: cmd.resolve  = 1'b1;
            ST_UPDATE:  cmd.update   = 1'b1;
            ST_OUT:     cmd.out_load = sts.out_free;
            default:    cmd          = '0;
        endcase
    end

endmodule

@@ rtl/core/mfac_datapath.sv @@
`timescale 1ns / 1ps
module mfac_datapath import mfac_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int FRAME_BITS  = 32,
    parameter int KEY_BITS    = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  cmd_t      cmd,
    output sts_t      sts
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = ((FRAME_BITS > 32) ? FRAME_BITS : 32) + 1;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [FRAME_BITS-1:0] last;
        logic                  av;
        logic [31:0]           ae;
        logic [30:0]           at;
        logic                  pv;
        logic [31:0]           pe;
        logic [30:0]           pt;
        logic [7:0]            streak;
        logic [7:0]            miss;
        logic [FRAME_BITS-1:0] cd;
    } rec_t;

    // configuration
    logic [7:0]  cf_reg, ml_reg;
    logic [31:0] cdl_reg;
    logic [17:0] mth_reg, hyb_reg;
    logic [6:0]  elim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cf_reg   <= RST_CONFIRM_FRAMES;
            ml_reg   <= RST_MISS_LIMIT;
            cdl_reg  <= RST_COOLDOWN_LENGTH;
            mth_reg  <= RST_MARGIN_THRESHOLD;
            hyb_reg  <= RST_HYSTERESIS_BONUS;
            elim_reg <= RST_ENTRY_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CONFIRM_FRAMES:   cf_reg   <= cfg_wdata[7:0];
                CFG_MISS_LIMIT:       ml_reg   <= cfg_wdata[7:0];
                CFG_COOLDOWN_LENGTH:  cdl_reg  <= cfg_wdata;
                CFG_MARGIN_THRESHOLD: mth_reg  <= cfg_wdata[17:0];
                CFG_HYSTERESIS_BONUS: hyb_reg  <= cfg_wdata[17:0];
                CFG_ENTRY_LIMIT:      elim_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // captured input
    in_item_t in_reg;
    logic [KEY_BITS-1:0]   key_in;
    logic [FRAME_BITS-1:0] frame_in;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
    end

    assign key_in   = KEY_BITS'(in_reg.candidate_key);
    assign frame_in = FRAME_BITS'(in_reg.frame_number);

    assign sts.in_invalid = (key_in == '0) || (frame_in == '0) ||
                            (in_reg.top_score > SCORE_ONE) ||
                            (in_reg.next_score > SCORE_ONE) ||
                            (in_reg.target_present &&
                             ((in_reg.target_epoch == '0) || in_reg.target_tracklet[31]));

    // entry store
    logic [MAX_ENTRIES-1:0] used_reg;
    logic          ram_we;
    logic [AW-1:0] rd_addr;
    rec_t          ram_q, nrec;

    logic [CW-1:0] cnt_reg;
    logic          rd_pend_reg;
    logic [AW-1:0] rd_addr_reg;

    // scan bookkeeping
    logic          found_reg, victim_v_reg, free_v_reg;
    logic [AW-1:0] slot_reg, victim_reg, free_reg;
    logic [FRAME_BITS-1:0] vframe_reg;
    logic [KEY_BITS-1:0]   vkey_reg;
    logic [CW-1:0] used_cnt_reg;
    rec_t          rec_reg, blank_rec;
    logic          reject_reg, cons_reg;
    logic          hit_used, take_victim;

    assign rd_addr = cnt_reg[AW-1:0];

    mfac_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (nrec),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign sts.scan_done = (cnt_reg == CW'(MAX_ENTRIES)) && !rd_pend_reg;
    assign hit_used      = used_reg[rd_addr_reg];
    assign take_victim   = !victim_v_reg || (ram_q.last < vframe_reg) ||
                           ((ram_q.last == vframe_reg) && (ram_q.key < vkey_reg));

    // record for a newly created entry
    always_comb begin
        blank_rec     = '0;
        blank_rec.key = key_in;
    end

    // effective entry limit
    logic [8:0] lim9;
    logic       need_evict;
    always_comb begin
        lim9 = {2'b00, elim_reg};
        if (lim9 == 9'd0) begin
            lim9 = 9'd1;
        end else if (lim9 > 9'(MAX_ENTRIES)) begin
            lim9 = 9'(MAX_ENTRIES);
        end
    end
    assign need_evict = ((9'(used_cnt_reg) >= lim9) || !free_v_reg) && victim_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.scan_rd && (cnt_reg != CW'(MAX_ENTRIES));
            if (cmd.capture) begin
                cnt_reg      <= '0;
                found_reg    <= 1'b0;
                victim_v_reg <= 1'b0;
                free_v_reg   <= 1'b0;
                used_cnt_reg <= '0;
            end
            if (cmd.scan_rd && (cnt_reg != CW'(MAX_ENTRIES))) begin
                cnt_reg     <= cnt_reg + 1'b1;
                rd_addr_reg <= rd_addr;
            end
            if (rd_pend_reg) begin
                if (hit_used) begin
                    used_cnt_reg <= used_cnt_reg + 1'b1;
                    if (!found_reg && (ram_q.key == key_in)) begin
                        found_reg <= 1'b1;
                        slot_reg  <= rd_addr_reg;
                        rec_reg   <= ram_q;
                    end
                    if (take_victim) begin
                        victim_v_reg <= 1'b1;
                        victim_reg   <= rd_addr_reg;
                        vframe_reg   <= ram_q.last;
                        vkey_reg     <= ram_q.key;
                    end
                end else if (!free_v_reg) begin
                    free_v_reg <= 1'b1;
                    free_reg   <= rd_addr_reg;
                end
            end
            if (cmd.resolve) begin
                reject_reg <= sts.in_invalid || (found_reg && (frame_in <= rec_reg.last));
                cons_reg   <= !found_reg || (frame_in == rec_reg.last + 1'b1);
                if (!found_reg) begin
                    rec_reg     <= blank_rec;
                    slot_reg    <= need_evict ? victim_reg :
                                   (free_v_reg ? free_reg : '0);
                end
            end
        end
    end

    // per-item update
    out_item_t res;
    always_comb begin
        logic [7:0]  cf, ml, miss_inc, strk;
        logic [30:0] tr;
        logic [SW-1:0] cd_sum;
        logic signed [19:0] margin;
        logic same, fresh;
        cf       = (cf_reg == 8'd0) ? 8'd1 : cf_reg;
        ml       = (ml_reg == 8'd0) ? 8'd1 : ml_reg;
        tr       = in_reg.target_tracklet[30:0];
        miss_inc = (rec_reg.miss == 8'hFF) ? rec_reg.miss : rec_reg.miss + 8'd1;
        cd_sum   = SW'(frame_in) + SW'(cdl_reg);
        same     = rec_reg.av && (rec_reg.ae == in_reg.target_epoch) && (rec_reg.at == tr);
        margin   = $signed({3'b000, in_reg.top_score}) - $signed({3'b000, in_reg.next_score})
                   + (same ? $signed({2'b00, hyb_reg}) : 20'sd0);
        fresh    = !cons_reg || !rec_reg.pv || (rec_reg.pe != in_reg.target_epoch) ||
                   (rec_reg.pt != tr);
        strk     = fresh ? 8'd1 : ((rec_reg.streak == 8'hFF) ? 8'hFF : rec_reg.streak + 8'd1);

        nrec      = rec_reg;
        nrec.last = frame_in;
        res       = '0;
        res.attached_valid = rec_reg.av;
        res.attached_epoch = rec_reg.ae;
        res.attached_tracklet = rec_reg.at;

        if (reject_reg) begin
            res = '0;
            res.decision = DEC_REJECTED;
        end else if (!rec_reg.av && (rec_reg.cd != '0) && (frame_in <= rec_reg.cd)) begin
            nrec.pv      = 1'b0;
            nrec.streak  = 8'd0;
            res.decision = DEC_COOLDOWN;
        end else if (!in_reg.gate_ok || !in_reg.target_present) begin
            nrec.pv      = 1'b0;
            nrec.streak  = 8'd0;
            res.decision = DEC_UNMATCHED;
            if (rec_reg.av && (miss_inc < ml)) begin
                nrec.miss    = miss_inc;
                res.decision = DEC_MATCHED;
            end else if (rec_reg.av) begin
                // detach and start cooldown, saturating at the largest frame
                nrec.av   = 1'b0;
                nrec.miss = 8'd0;
                nrec.cd   = (cd_sum > SW'({FRAME_BITS{1'b1}})) ? '1 :
                            cd_sum[FRAME_BITS-1:0];
                res.attached_valid = 1'b0;
            end
        end else if (in_reg.split_merge_flag || (margin < $signed({2'b00, mth_reg}))) begin
            nrec.pv      = 1'b0;
            nrec.streak  = 8'd0;
            res.decision = DEC_AMBIGUOUS;
        end else if (same) begin
            nrec.miss     = 8'd0;
            res.decision  = DEC_MATCHED;
            res.hit_count = cf;
        end else begin
            nrec.pv       = 1'b1;
            nrec.pe       = in_reg.target_epoch;
            nrec.pt       = tr;
            nrec.streak   = strk;
            res.hit_count = strk;
            res.decision  = DEC_TENTATIVE;
            if (strk >= cf) begin
                nrec.av  = 1'b1;
                nrec.ae  = in_reg.target_epoch;
                nrec.at  = tr;
                nrec.pv  = 1'b0;
                nrec.miss = 8'd0;
                res.decision = DEC_MATCHED;
                res.attached_valid = 1'b1;
                res.attached_epoch = in_reg.target_epoch;
                res.attached_tracklet = tr;
            end
        end
        if (!res.attached_valid) begin
            res.attached_epoch    = '0;
            res.attached_tracklet = '0;
        end
    end

    assign ram_we = cmd.update && !reject_reg;

    out_item_t res_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (ram_we) begin
            used_reg[slot_reg] <= 1'b1;
        end
        if (cmd.update) begin
            res_reg <= res;
        end
    end

    // output register
    logic      m_valid_reg;
    out_item_t m_data_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/multi_frame_association_confirm_core.sv @@
// Items are taken one at a time; a new item is accepted only after the last result is loaded.
// A well-formed item scans every entry through the single read port of the entry RAM, one
// entry per cycle; a malformed item skips the scan.
// A finished result waits in the output register while the next item is taken.
// Reset (aresetn low, synchronous) clears the entry valid bits and restores register defaults;
// there is no RAM clearing pass.
`timescale 1ns / 1ps
`include "multi_frame_association_confirm_core_defines.svh"
module multi_frame_association_confirm_core import mfac_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int FRAME_BITS  = 32,
    parameter int KEY_BITS    = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    mfac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mfac_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .FRAME_BITS  (FRAME_BITS),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    `MFAC_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "second item taken mid-flight")
    `MFAC_ASSERT_NEXT(a_out_load, cmd.out_load, m_valid, "result load lost")
    `MFAC_ASSERT_NOW(a_no_write_in_scan, cmd.scan_rd, !cmd.update, "entry write during scan")

endmodule

@@ dv/multi_frame_association_confirm_core_test.sv @@
`timescale 1ns / 1ps
module multi_frame_association_confirm_core_test;
    import mfac_pkg::*;

    localparam int SLOTS = 64;
    localparam int DRAIN_CYCLES = 200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_CONFIRM_FRAMES;
    logic [31:0] cfg_wdata = '0;

    always #2 aclk = ~aclk;

    multi_frame_association_confirm_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predictor copy of the registers and the candidate table
    logic [7:0]  p_confirm;
    logic [7:0]  p_miss_lim;
    logic [31:0] p_cool_len;
    logic [17:0] p_margin_thr;
    logic [17:0] p_hyst;
    logic [6:0]  p_entry_lim;

    logic        t_used [SLOTS];
    logic [31:0] t_key [SLOTS];
    logic [31:0] t_last [SLOTS];
    logic        t_att [SLOTS];
    logic [31:0] t_att_ep [SLOTS];
    logic [30:0] t_att_tr [SLOTS];
    logic        t_pend [SLOTS];
    logic [31:0] t_pend_ep [SLOTS];
    logic [30:0] t_pend_tr [SLOTS];
    logic [7:0]  t_streak [SLOTS];
    logic [7:0]  t_miss [SLOTS];
    logic [31:0] t_cool_end [SLOTS];

    in_item_t  obs_queue[$];
    out_item_t decision_queue[$];
    int        mismatches = 0;
    bit        quiet = 1'b0;
    bit        send_pause = 1'b0;
    bit        hold_sink = 1'b0;
    int        src_gap = 0;
    int        sink_gap = 0;

    function automatic out_item_t verdict(logic [2:0] d, logic av, logic [31:0] ep,
                                          logic [30:0] tr, logic [7:0] hits);
        out_item_t r;
        r.decision = d;
        r.attached_valid = av;
        r.attached_epoch = av ? ep : 32'd0;
        r.attached_tracklet = av ? tr : 31'd0;
        r.hit_count = hits;
        return r;
    endfunction

    function automatic void wipe_slot(int i);
        t_used[i] = 0; t_key[i] = 0; t_last[i] = 0;
        t_att[i] = 0; t_att_ep[i] = 0; t_att_tr[i] = 0;
        t_pend[i] = 0; t_pend_ep[i] = 0; t_pend_tr[i] = 0;
        t_streak[i] = 0; t_miss[i] = 0; t_cool_end[i] = 0;
    endfunction

    function automatic int claim_slot();
        int used, free_s, victim, lim;
        used = 0; free_s = -1; victim = -1;
        lim = (p_entry_lim == 0) ? 1 : ((p_entry_lim > SLOTS) ? SLOTS : p_entry_lim);
        for (int i = 0; i < SLOTS; i++) begin
            if (t_used[i]) begin
                used++;
                if (victim < 0 || t_last[i] < t_last[victim] ||
                    (t_last[i] == t_last[victim] && t_key[i] < t_key[victim]))
                    victim = i;
            end else if (free_s < 0) begin
                free_s = i;
            end
        end
        if ((used >= lim || free_s < 0) && victim >= 0) begin
            wipe_slot(victim);
            return victim;
        end
        return (free_s >= 0) ? free_s : 0;
    endfunction

    function automatic out_item_t confirm_step(in_item_t o);
        int s, cf, ml;
        bit consec, same;
        longint margin;
        logic [30:0] tr;
        s = -1;
        cf = (p_confirm == 0) ? 1 : p_confirm;
        ml = (p_miss_lim == 0) ? 1 : p_miss_lim;
        tr = o.target_tracklet[30:0];
        if (o.candidate_key == 0 || o.frame_number == 0 || o.top_score > SCORE_ONE ||
            o.next_score > SCORE_ONE ||
            (o.target_present && (o.target_epoch == 0 || o.target_tracklet[31])))
            return verdict(DEC_REJECTED, 0, 0, 0, 0);
        for (int i = 0; i < SLOTS; i++)
            if (s < 0 && t_used[i] && t_key[i] == o.candidate_key) s = i;
        if (s >= 0) begin
            if (o.frame_number <= t_last[s]) return verdict(DEC_REJECTED, 0, 0, 0, 0);
            consec = (o.frame_number == t_last[s] + 32'd1);
        end else begin
            s = claim_slot();
            wipe_slot(s);
            t_used[s] = 1;
            t_key[s] = o.candidate_key;
            consec = 1;
        end
        t_last[s] = o.frame_number;
        if (!t_att[s] && t_cool_end[s] != 0 && o.frame_number <= t_cool_end[s]) begin
            t_pend[s] = 0; t_streak[s] = 0;
            return verdict(DEC_COOLDOWN, 0, 0, 0, 0);
        end
        if (!o.gate_ok || !o.target_present) begin
            t_pend[s] = 0; t_streak[s] = 0;
            if (t_att[s]) begin
                if (t_miss[s] != 8'hFF) t_miss[s]++;
                if (t_miss[s] < ml) return verdict(DEC_MATCHED, 1, t_att_ep[s], t_att_tr[s], 0);
                t_att[s] = 0; t_miss[s] = 0;
                if ({32'd0, p_cool_len} > 64'hFFFF_FFFF - o.frame_number)
                    t_cool_end[s] = 32'hFFFF_FFFF;
                else
                    t_cool_end[s] = o.frame_number + p_cool_len;
            end
            return verdict(DEC_UNMATCHED, 0, 0, 0, 0);
        end
        same = t_att[s] && t_att_ep[s] == o.target_epoch && t_att_tr[s] == tr;
        margin = longint'(o.top_score) - longint'(o.next_score) +
                 (same ? longint'(p_hyst) : 0);
        if (o.split_merge_flag || margin < longint'(p_margin_thr)) begin
            t_pend[s] = 0; t_streak[s] = 0;
            return verdict(DEC_AMBIGUOUS, t_att[s], t_att_ep[s], t_att_tr[s], 0);
        end
        if (same) begin
            t_miss[s] = 0;
            return verdict(DEC_MATCHED, 1, t_att_ep[s], t_att_tr[s], cf[7:0]);
        end
        if (!consec || !t_pend[s] || t_pend_ep[s] != o.target_epoch || t_pend_tr[s] != tr) begin
            t_pend[s] = 1; t_pend_ep[s] = o.target_epoch; t_pend_tr[s] = tr;
            t_streak[s] = 1;
        end else if (t_streak[s] != 8'hFF) begin
            t_streak[s]++;
        end
        if (t_streak[s] >= cf) begin
            t_att[s] = 1; t_att_ep[s] = t_pend_ep[s]; t_att_tr[s] = t_pend_tr[s];
            t_pend[s] = 0; t_miss[s] = 0;
            return verdict(DEC_MATCHED, 1, t_att_ep[s], t_att_tr[s], t_streak[s]);
        end
        return verdict(DEC_TENTATIVE, t_att[s], t_att_ep[s], t_att_tr[s], t_streak[s]);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decision_queue.push_back(confirm_step(s_data));
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (obs_queue.size() > 0 && !send_pause) begin
                    s_data <= obs_queue.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (decision_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'(m_data.decision), 0);
                end else begin
                    want = decision_queue.pop_front();
                    if (m_data.decision !== want.decision)
                        report_mismatch("decision", 32'(m_data.decision), 32'(want.decision));
                    if (m_data.attached_valid !== want.attached_valid)
                        report_mismatch("attached_valid", 32'(m_data.attached_valid),
                                        32'(want.attached_valid));
                    if (m_data.attached_epoch !== want.attached_epoch)
                        report_mismatch("attached_epoch", m_data.attached_epoch,
                                        want.attached_epoch);
                    if (m_data.attached_tracklet !== want.attached_tracklet)
                        report_mismatch("attached_tracklet", 32'(m_data.attached_tracklet),
                                        32'(want.attached_tracklet));
                    if (m_data.hit_count !== want.hit_count)
                        report_mismatch("hit_count", 32'(m_data.hit_count), 32'(want.hit_count));
                end
            end
            if (hold_sink) begin
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t make_obs(logic [31:0] key, logic [31:0] frame,
                                          logic [16:0] top, logic [16:0] runner_up,
                                          logic gates, logic present, logic [31:0] ep,
                                          logic [31:0] tr, logic split);
        in_item_t o;
        o.candidate_key = key; o.frame_number = frame;
        o.top_score = top; o.next_score = runner_up;
        o.gate_ok = gates; o.target_present = present;
        o.target_epoch = ep; o.target_tracklet = tr; o.split_merge_flag = split;
        return o;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CONFIRM_FRAMES:   p_confirm = value[7:0];
            CFG_MISS_LIMIT:       p_miss_lim = value[7:0];
            CFG_COOLDOWN_LENGTH:  p_cool_len = value;
            CFG_MARGIN_THRESHOLD: p_margin_thr = value[17:0];
            CFG_HYSTERESIS_BONUS: p_hyst = value[17:0];
            CFG_ENTRY_LIMIT:      p_entry_lim = value[6:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (obs_queue.size() == 0 && !s_valid && decision_queue.size() == 0);
        repeat (10) @(posedge aclk);
    endtask

    // well-formed tracks over a small key pool with random content and rare noise
    task automatic random_tracks(int count, int keys, logic [31:0] frame_base);
        logic [31:0] fr [16];
        logic [31:0] ep, tr;
        int k;
        for (int i = 0; i < 16; i++) fr[i] = frame_base;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, keys - 1);
            fr[k] += ($urandom_range(0, 4) == 0) ? $urandom_range(2, 6) : 1;
            ep = $urandom_range(1, 2);
            tr = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0)
                obs_queue.push_back(make_obs($urandom, $urandom, 17'($urandom), 17'($urandom),
                                             1'($urandom), 1'($urandom), $urandom, $urandom,
                                             1'($urandom)));
            else
                obs_queue.push_back(make_obs(32'h100 + k, fr[k],
                    17'($urandom_range(20000, 65536)), 17'($urandom_range(0, 15000)),
                    $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                    ($urandom_range(0, 20) == 0) ? $urandom : ep,
                    ($urandom_range(0, 20) == 0) ? $urandom : tr,
                    $urandom_range(0, 9) == 0));
        end
    endtask

    initial begin
        p_confirm = RST_CONFIRM_FRAMES; p_miss_lim = RST_MISS_LIMIT;
        p_cool_len = RST_COOLDOWN_LENGTH; p_margin_thr = RST_MARGIN_THRESHOLD;
        p_hyst = RST_HYSTERESIS_BONUS; p_entry_lim = RST_ENTRY_LIMIT;
        for (int i = 0; i < SLOTS; i++) wipe_slot(i);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: rejects, extremes, confirm, misses, cooldown, ambiguity
        obs_queue.push_back(make_obs(0, 5, 0, 0, 1, 1, 1, 1, 0));
        obs_queue.push_back(make_obs(7, 0, 0, 0, 1, 1, 1, 1, 0));
        obs_queue.push_back(make_obs(7, 5, 17'h1FFFF, 0, 1, 1, 1, 1, 0));
        obs_queue.push_back(make_obs(7, 5, 0, 17'd65537, 1, 1, 1, 1, 0));
        obs_queue.push_back(make_obs(7, 5, 65536, 0, 1, 1, 0, 1, 0));
        obs_queue.push_back(make_obs(7, 5, 65536, 0, 1, 1, 9, 32'h8000_0000, 0));
        for (int f = 1; f <= 4; f++)
            obs_queue.push_back(make_obs(32'hFFFF_FFFF, f, 65536, 0, 1, 1,
                                         32'hFFFF_FFFF, 32'h7FFF_FFFF, 0));
        obs_queue.push_back(make_obs(32'hFFFF_FFFF, 4, 65536, 0, 1, 1, 1, 1, 0));
        obs_queue.push_back(make_obs(32'hFFFF_FFFF, 5, 65536, 60000, 1, 1, 3, 3, 0));
        obs_queue.push_back(make_obs(32'hFFFF_FFFF, 6, 65536, 0, 1, 1, 3, 3, 1));
        for (int f = 7; f <= 9; f++)
            obs_queue.push_back(make_obs(32'hFFFF_FFFF, f, 0, 0, 0, 0, 0, 0, 0));
        obs_queue.push_back(make_obs(32'hFFFF_FFFF, 12, 65536, 0, 1, 1, 3, 3, 0));
        obs_queue.push_back(make_obs(32'hFFFF_FFFF, 20, 65536, 0, 1, 1, 3, 3, 0));
        obs_queue.push_back(make_obs(32'hFFFF_FFFF, 32'hFFFF_FFFE, 65536, 0, 1, 1, 3, 3, 0));
        drain();

        // extremes: confirm 0, miss 0, max cooldown (saturating end), tiny table
        write_reg(CFG_CONFIRM_FRAMES, 0);
        write_reg(CFG_MISS_LIMIT, 0);
        write_reg(CFG_COOLDOWN_LENGTH, 32'hFFFF_FFFF);
        write_reg(CFG_MARGIN_THRESHOLD, 0);
        write_reg(CFG_HYSTERESIS_BONUS, 131072);
        write_reg(CFG_ENTRY_LIMIT, 0);
        random_tracks(120, 4, 32'd1000);
        drain();

        write_reg(CFG_CONFIRM_FRAMES, 255);
        write_reg(CFG_MISS_LIMIT, 255);
        write_reg(CFG_COOLDOWN_LENGTH, 0);
        write_reg(CFG_MARGIN_THRESHOLD, 131072);
        write_reg(CFG_HYSTERESIS_BONUS, 0);
        write_reg(CFG_ENTRY_LIMIT, 127);
        random_tracks(60, 3, 32'd5000);
        drain();

        // long receiver hold while the sender keeps offering
        write_reg(CFG_CONFIRM_FRAMES, 2);
        write_reg(CFG_MISS_LIMIT, 2);
        write_reg(CFG_COOLDOWN_LENGTH, 5);
        write_reg(CFG_MARGIN_THRESHOLD, 6554);
        write_reg(CFG_HYSTERESIS_BONUS, 3277);
        write_reg(CFG_ENTRY_LIMIT, 5);
        hold_sink = 1'b1;
        random_tracks(200, 8, 32'd9000);
        repeat (1500) @(posedge aclk);
        hold_sink = 1'b0;
        drain();

        // sender pause mid-stream until everything has come back
        random_tracks(200, 12, 32'd20000);
        repeat (3000) @(posedge aclk);
        send_pause = 1'b1;
        wait (!s_valid && decision_queue.size() == 0);
        repeat (20) @(posedge aclk);
        send_pause = 1'b0;
        drain();

        write_reg(CFG_ENTRY_LIMIT, 64);
        write_reg(CFG_CONFIRM_FRAMES, 3);
        quiet = 1'b1;
        random_tracks(220, 16, 32'd40000);
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && decision_queue.size() == 0)
            $display("multi_frame_association_confirm_core regression: pass");
        else
            $display("multi_frame_association_confirm_core regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("multi_frame_association_confirm_core regression: fail");
        $finish;
    end
endmodule
